// ===== design/assert_macros.svh =====
// Assertion helpers for the design files (included by sbq_core).
// In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBQ_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
`define SBQ_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SBQ_ASSERT(name, clk, rst_n, prop)
`define SBQ_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

// ===== design/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg: stereo biquad shared definitions
// Widths, register map, control structs and fixed-point helper functions.
// ----------------------------------------------------------------------------
package sbq_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 26;
    localparam int COEF_FRAC_BITS = 22;
    localparam int STATE_WIDTH    = 48;

    localparam int PROD_WIDTH   = STATE_WIDTH + COEF_WIDTH;
    localparam int BX_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH    = STATE_WIDTH + 2;
    localparam int MAG_WIDTH    = PROD_WIDTH - COEF_FRAC_BITS;
    localparam int YLIM_EXP     = COEF_FRAC_BITS + SAMPLE_WIDTH;
    localparam int YC_WIDTH     = YLIM_EXP + 2;
    localparam int OUT_SHIFT    = COEF_FRAC_BITS + SAMPLE_WIDTH - 1;
    localparam int SCALED_WIDTH = YLIM_EXP + SAMPLE_WIDTH;
    localparam int QUOT_WIDTH   = SCALED_WIDTH - OUT_SHIFT;
    localparam int TDATA_WIDTH  = 2 * SAMPLE_WIDTH;

    localparam int MUL_STEPS = COEF_WIDTH;
    localparam int CNT_WIDTH = $clog2(MUL_STEPS);
    localparam logic [CNT_WIDTH-1:0] MUL_LAST = CNT_WIDTH'(MUL_STEPS - 1);
    localparam int NUM_LANES = 3;

    localparam int REG_COUNT      = 6;
    localparam int ADDR_WIDTH     = $clog2(REG_COUNT * 4);
    localparam int IDX_WIDTH      = ADDR_WIDTH - 2;
    localparam int APB_DATA_WIDTH = 32;

    // magnitude limits for a saturated coefficient product
    localparam logic [MAG_WIDTH-1:0] MAG_NEG_LIM = MAG_WIDTH'(1) << (STATE_WIDTH - 1);
    localparam logic [MAG_WIDTH-1:0] MAG_POS_LIM = MAG_NEG_LIM - MAG_WIDTH'(1);

    // clamp window for y ahead of the sample conversion
    localparam logic [STATE_WIDTH-1:0] Y_POS_LIM = STATE_WIDTH'(1) << YLIM_EXP;
    localparam logic [STATE_WIDTH-1:0] Y_NEG_LIM = ~Y_POS_LIM + STATE_WIDTH'(1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
        logic  enable;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctrl_t;

    typedef struct packed {
        logic    valid;
        logic    last;
        sample_t left;
        sample_t right;
    } core_res_t;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2,
        REG_ENABLE
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULX,
        ST_SUMY,
        ST_LOADY,
        ST_MULY,
        ST_UPD1,
        ST_UPD2,
        ST_HOLD
    } core_state_t;

    function automatic logic [COEF_WIDTH-1:0] abs_coef(input coef_t c);
        logic [COEF_WIDTH-1:0] u;
        u = c;
        return c[COEF_WIDTH-1] ? (~u + COEF_WIDTH'(1)) : u;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] abs_sample(input sample_t s);
        logic [SAMPLE_WIDTH-1:0] u;
        u = s;
        return s[SAMPLE_WIDTH-1] ? (~u + SAMPLE_WIDTH'(1)) : u;
    endfunction

    function automatic logic [STATE_WIDTH-1:0] abs_state(input logic [STATE_WIDTH-1:0] v);
        return v[STATE_WIDTH-1] ? (~v + STATE_WIDTH'(1)) : v;
    endfunction

    // saturate a wide two's complement sum to the state range
    function automatic logic [STATE_WIDTH-1:0] sat_state(input logic [SUM_WIDTH-1:0] v);
        logic [SUM_WIDTH-STATE_WIDTH:0] upper;
        upper = v[SUM_WIDTH-1:STATE_WIDTH-1];
        if (&upper || ~|upper)
            return v[STATE_WIDTH-1:0];
        return {v[SUM_WIDTH-1], {(STATE_WIDTH-1){~v[SUM_WIDTH-1]}}};
    endfunction

    // product magnitude >> frac bits, clipped to the limit of its sign
    function automatic logic [STATE_WIDTH-1:0] mag_sat(input logic [PROD_WIDTH-1:0] p,
                                                        input logic neg);
        logic [MAG_WIDTH-1:0] m;
        logic [MAG_WIDTH-1:0] lim;
        m   = p[PROD_WIDTH-1:COEF_FRAC_BITS];
        lim = neg ? MAG_NEG_LIM : MAG_POS_LIM;
        if (m > lim)
            return lim[STATE_WIDTH-1:0];
        return m[STATE_WIDTH-1:0];
    endfunction

endpackage

// ===== design/sbq_mul.sv =====
// ----------------------------------------------------------------------------
// sbq_mul: bit-serial shift-add multiplier lane
// Unsigned magnitudes; one multiplier bit per step, LSB first. The product
// bits shift down through the multiplier register.
// ----------------------------------------------------------------------------
module sbq_mul (
    input  logic                                 clk,
    input  sbq_pkg::mul_ctrl_t                   ctrl,
    input  logic [sbq_pkg::STATE_WIDTH-1:0]      mcand,
    input  logic [sbq_pkg::COEF_WIDTH-1:0]       mplier,
    output logic [sbq_pkg::PROD_WIDTH-1:0]       product
);
    import sbq_pkg::*;

    logic [STATE_WIDTH-1:0] mcand_reg;
    logic [STATE_WIDTH-1:0] acc_reg;
    logic [COEF_WIDTH-1:0]  q_reg;
    logic [STATE_WIDTH:0]   add_next;

    assign add_next = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mcand_reg <= mcand;
            acc_reg   <= '0;
            q_reg     <= mplier;
        end
        else if (ctrl.step)
        begin
            {acc_reg, q_reg} <= {add_next, q_reg[COEF_WIDTH-1:1]};
        end
    end

    assign product = {acc_reg, q_reg};

endmodule

// ===== design/sbq_regs.sv =====
// ----------------------------------------------------------------------------
// sbq_regs: APB register file
// Five Q3.22 coefficients and the filter enable. A write that turns the
// enable on flags a clear of the delay state.
// ----------------------------------------------------------------------------
module sbq_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sbq_pkg::ADDR_WIDTH-1:0]        paddr,
    input  logic [sbq_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [sbq_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready,
    output sbq_pkg::cfg_t                         cfg,
    output logic                                  clear_state
);
    import sbq_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_B0:     cfg_next.b0 = coef_t'(pwdata[COEF_WIDTH-1:0]);
                REG_B1:     cfg_next.b1 = coef_t'(pwdata[COEF_WIDTH-1:0]);
                REG_B2:     cfg_next.b2 = coef_t'(pwdata[COEF_WIDTH-1:0]);
                REG_A1:     cfg_next.a1 = coef_t'(pwdata[COEF_WIDTH-1:0]);
                REG_A2:     cfg_next.a2 = coef_t'(pwdata[COEF_WIDTH-1:0]);
                REG_ENABLE: cfg_next.enable = pwdata[0];
                default:    ;
            endcase
        end
    end

    assign clear_state = wr && (idx == REG_ENABLE) && pwdata[0] && !cfg_reg.enable;

    always_comb
    begin
        case (idx)
            REG_B0:     prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg_reg.b0};
            REG_B1:     prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg_reg.b1};
            REG_B2:     prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg_reg.b2};
            REG_A1:     prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg_reg.a1};
            REG_A2:     prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg_reg.a2};
            REG_ENABLE: prdata = {{(APB_DATA_WIDTH-1){1'b0}}, cfg_reg.enable};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/sbq_core.sv =====
// ----------------------------------------------------------------------------
// sbq_core: biquad sequencer and datapath
// Runs left then right through the TDF-II biquad using three serial
// multiplier lanes: b0/b1/b2 times x first, then a1/a2 times y.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbq_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbq_pkg::cfg_t        cfg,
    input  logic                 clear_state,
    input  logic                 start,
    input  sbq_pkg::sample_t     in_left,
    input  sbq_pkg::sample_t     in_right,
    input  logic                 in_last,
    input  logic                 out_free,
    output logic                 ready,
    output sbq_pkg::core_res_t   res
);
    import sbq_pkg::*;

    core_state_t            state_reg;
    core_state_t            state_next;
    logic                   chan_reg;
    logic                   chan_next;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [CNT_WIDTH-1:0]   cnt_next;

    mul_ctrl_t              mul_ctrl;
    logic                   sumy_en;
    logic                   upd1_en;
    logic                   upd2_en;
    logic                   bypass_ld;

    logic [STATE_WIDTH-1:0] mcand;
    logic [COEF_WIDTH-1:0]  mplier [NUM_LANES];
    logic [PROD_WIDTH-1:0]  prod [NUM_LANES];
    logic [NUM_LANES-1:0]   neg_load;
    logic [NUM_LANES-1:0]   neg_reg;

    sample_t                x_sel;
    sample_t                x_right_reg;
    logic                   last_reg;

    logic [STATE_WIDTH-1:0] d1_reg [2];
    logic [STATE_WIDTH-1:0] d2_reg [2];
    logic [STATE_WIDTH-1:0] d1_sel;
    logic [STATE_WIDTH-1:0] d2_sel;
    logic [STATE_WIDTH-1:0] y_reg;
    logic [STATE_WIDTH-1:0] t_reg;
    logic [STATE_WIDTH-1:0] n2_reg;
    logic [BX_WIDTH-1:0]    bx1_reg;
    logic [BX_WIDTH-1:0]    bx2_reg;
    logic [BX_WIDTH-1:0]    mag1;
    logic [BX_WIDTH-1:0]    mag2;

    logic [SUM_WIDTH-1:0]   y_sum;
    logic [SUM_WIDTH-1:0]   t_sum;
    logic [SUM_WIDTH-1:0]   n1_sum;
    logic [SUM_WIDTH-1:0]   n2_sum;
    logic [SUM_WIDTH-1:0]   prod0_ext;
    logic [SUM_WIDTH-1:0]   m1_ext;
    logic [SUM_WIDTH-1:0]   m2_ext;
    logic [STATE_WIDTH-1:0] m1;
    logic [STATE_WIDTH-1:0] m2;

    logic [STATE_WIDTH-1:0]  y_clip;
    logic [YC_WIDTH-1:0]     yc;
    logic [SCALED_WIDTH-1:0] yc_ext;
    logic [SCALED_WIDTH-1:0] p_next;
    logic [SCALED_WIDTH-1:0] p_reg;
    logic [SCALED_WIDTH-1:0] q_biased;
    logic [QUOT_WIDTH-1:0]   q;
    logic [QUOT_WIDTH-SAMPLE_WIDTH:0] q_upper;
    sample_t                 q_sat;
    sample_t                 res_left_reg;
    sample_t                 res_right_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        mul_ctrl   = '0;
        sumy_en    = 1'b0;
        upd1_en    = 1'b0;
        upd2_en    = 1'b0;
        bypass_ld  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cfg.enable)
                    begin
                        mul_ctrl.load = 1'b1;
                        chan_next     = 1'b0;
                        cnt_next      = '0;
                        state_next    = ST_MULX;
                    end
                    else
                    begin
                        bypass_ld  = 1'b1;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_MULX:
            begin
                mul_ctrl.step = 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SUMY;
                end
                else
                    cnt_next = cnt_reg + CNT_WIDTH'(1);
            end
            ST_SUMY:
            begin
                sumy_en    = 1'b1;
                state_next = ST_LOADY;
            end
            ST_LOADY:
            begin
                mul_ctrl.load = 1'b1;
                state_next    = ST_MULY;
            end
            ST_MULY:
            begin
                mul_ctrl.step = 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_UPD1;
                end
                else
                    cnt_next = cnt_reg + CNT_WIDTH'(1);
            end
            ST_UPD1:
            begin
                upd1_en    = 1'b1;
                state_next = ST_UPD2;
            end
            ST_UPD2:
            begin
                upd2_en = 1'b1;
                if (!chan_reg)
                begin
                    // left done, start the right channel
                    mul_ctrl.load = 1'b1;
                    chan_next     = 1'b1;
                    state_next    = ST_MULX;
                end
                else
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ---------------- lane operands ----------------
    assign x_sel = (state_reg == ST_IDLE) ? in_left : x_right_reg;

    always_comb
    begin
        if (state_reg == ST_LOADY)
        begin
            mcand     = abs_state(y_reg);
            mplier[0] = abs_coef(cfg.a1);
            mplier[1] = abs_coef(cfg.a2);
            mplier[2] = '0;
            neg_load  = {1'b0,
                         y_reg[STATE_WIDTH-1] ^ cfg.a2[COEF_WIDTH-1],
                         y_reg[STATE_WIDTH-1] ^ cfg.a1[COEF_WIDTH-1]};
        end
        else
        begin
            mcand     = {{(STATE_WIDTH-SAMPLE_WIDTH){1'b0}}, abs_sample(x_sel)};
            mplier[0] = abs_coef(cfg.b0);
            mplier[1] = abs_coef(cfg.b1);
            mplier[2] = abs_coef(cfg.b2);
            neg_load  = {x_sel[SAMPLE_WIDTH-1] ^ cfg.b2[COEF_WIDTH-1],
                         x_sel[SAMPLE_WIDTH-1] ^ cfg.b1[COEF_WIDTH-1],
                         x_sel[SAMPLE_WIDTH-1] ^ cfg.b0[COEF_WIDTH-1]};
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        sbq_mul u_mul (
            .clk     (clk),
            .ctrl    (mul_ctrl),
            .mcand   (mcand),
            .mplier  (mplier[i]),
            .product (prod[i])
        );
    end

    // ---------------- datapath ----------------
    assign d1_sel = d1_reg[chan_reg];
    assign d2_sel = d2_reg[chan_reg];

    // y = d1 + b0*x, sign of the product applied as add or subtract
    assign prod0_ext = {{(SUM_WIDTH-BX_WIDTH){1'b0}}, prod[0][BX_WIDTH-1:0]};
    assign y_sum = neg_reg[0]
                 ? {{(SUM_WIDTH-STATE_WIDTH){d1_sel[STATE_WIDTH-1]}}, d1_sel} - prod0_ext
                 : {{(SUM_WIDTH-STATE_WIDTH){d1_sel[STATE_WIDTH-1]}}, d1_sel} + prod0_ext;

    assign mag1 = prod[1][BX_WIDTH-1:0];
    assign mag2 = prod[2][BX_WIDTH-1:0];

    // t = b1*x - a1*y and n2 = b2*x - a2*y
    assign m1     = mag_sat(prod[0], neg_reg[0]);
    assign m2     = mag_sat(prod[1], neg_reg[1]);
    assign m1_ext = {{(SUM_WIDTH-STATE_WIDTH){1'b0}}, m1};
    assign m2_ext = {{(SUM_WIDTH-STATE_WIDTH){1'b0}}, m2};
    assign t_sum  = neg_reg[0]
                  ? {{(SUM_WIDTH-BX_WIDTH){bx1_reg[BX_WIDTH-1]}}, bx1_reg} + m1_ext
                  : {{(SUM_WIDTH-BX_WIDTH){bx1_reg[BX_WIDTH-1]}}, bx1_reg} - m1_ext;
    assign n2_sum = neg_reg[1]
                  ? {{(SUM_WIDTH-BX_WIDTH){bx2_reg[BX_WIDTH-1]}}, bx2_reg} + m2_ext
                  : {{(SUM_WIDTH-BX_WIDTH){bx2_reg[BX_WIDTH-1]}}, bx2_reg} - m2_ext;

    assign n1_sum = {{(SUM_WIDTH-STATE_WIDTH){t_reg[STATE_WIDTH-1]}}, t_reg}
                  + {{(SUM_WIDTH-STATE_WIDTH){d2_sel[STATE_WIDTH-1]}}, d2_sel};

    // sample conversion: clip, times (2^15 - 1), truncate toward zero, clamp
    always_comb
    begin
        if ($signed(y_reg) > $signed(Y_POS_LIM))
            y_clip = Y_POS_LIM;
        else if ($signed(y_reg) < $signed(Y_NEG_LIM))
            y_clip = Y_NEG_LIM;
        else
            y_clip = y_reg;
    end

    assign yc      = y_clip[YC_WIDTH-1:0];
    assign yc_ext  = {{(SCALED_WIDTH-YC_WIDTH){yc[YC_WIDTH-1]}}, yc};
    assign p_next  = (yc_ext << (SAMPLE_WIDTH - 1)) - yc_ext;

    assign q_biased = p_reg + (p_reg[SCALED_WIDTH-1]
                    ? {{(SCALED_WIDTH-OUT_SHIFT){1'b0}}, {OUT_SHIFT{1'b1}}}
                    : {SCALED_WIDTH{1'b0}});
    assign q        = q_biased[SCALED_WIDTH-1:OUT_SHIFT];
    assign q_upper  = q[QUOT_WIDTH-1:SAMPLE_WIDTH-1];

    always_comb
    begin
        if (&q_upper || ~|q_upper)
            q_sat = sample_t'(q[SAMPLE_WIDTH-1:0]);
        else
            q_sat = sample_t'({q[QUOT_WIDTH-1], {(SAMPLE_WIDTH-1){~q[QUOT_WIDTH-1]}}});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_right_reg <= in_right;
            last_reg    <= in_last;
        end
        if (mul_ctrl.load)
            neg_reg <= neg_load;
        if (sumy_en)
        begin
            y_reg   <= sat_state(y_sum);
            bx1_reg <= neg_reg[1] ? (~mag1 + BX_WIDTH'(1)) : mag1;
            bx2_reg <= neg_reg[2] ? (~mag2 + BX_WIDTH'(1)) : mag2;
        end
        if (upd1_en)
        begin
            t_reg  <= sat_state(t_sum);
            n2_reg <= sat_state(n2_sum);
            p_reg  <= p_next;
        end
        if (bypass_ld)
        begin
            res_left_reg  <= in_left;
            res_right_reg <= in_right;
        end
        else if (upd2_en)
        begin
            if (chan_reg)
                res_right_reg <= q_sat;
            else
                res_left_reg <= q_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '{default: '0};
            d2_reg <= '{default: '0};
        end
        else if (clear_state)
        begin
            d1_reg <= '{default: '0};
            d2_reg <= '{default: '0};
        end
        else if (upd2_en)
        begin
            d1_reg[chan_reg] <= sat_state(n1_sum);
            d2_reg[chan_reg] <= n2_reg;
        end
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_HOLD);
    assign res.last  = last_reg;
    assign res.left  = res_left_reg;
    assign res.right = res_right_reg;

    `SBQ_ASSERT(a_start_idle, clk, rst_n, start |-> state_reg == ST_IDLE)
    `SBQ_ASSERT(a_muly_len, clk, rst_n, (state_reg == ST_MULY && cnt_reg == MUL_LAST) |=> state_reg == ST_UPD1)
    `SBQ_ASSERT(a_right_done, clk, rst_n, (state_reg == ST_UPD2 && chan_reg) |=> state_reg == ST_HOLD)
    `SBQ_ASSERT(a_hold_wait, clk, rst_n, (state_reg == ST_HOLD && !out_free) |=> state_reg == ST_HOLD)
    `SBQ_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_reg > MUL_LAST)

endmodule

// ===== design/stereo_biquad_df2t.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_df2t: stereo TDF-II biquad, APB configured, stream in/out
// Filtering: two channels in turn, each a 26-step bit-serial x pass (MULX), SUMY,
// LOADY, a 26-step bit-serial y pass (MULY), UPD1 and UPD2. A new frame is taken
// only in ST_IDLE, after the last result has moved to the output register.
// Bypass: the input frame goes straight to the result registers via ST_HOLD.
// Reset: coefficients, enable and delay state all zero; no clearing pass.
// ----------------------------------------------------------------------------
module stereo_biquad_df2t (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sbq_pkg::ADDR_WIDTH-1:0]        paddr,
    input  logic [sbq_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [sbq_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [sbq_pkg::TDATA_WIDTH-1:0]       s_tdata,  // left_sample, right_sample
    input  logic                                  s_tlast,  // frame_last
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sbq_pkg::TDATA_WIDTH-1:0]       m_tdata,  // left_result, right_result
    output logic                                  m_tlast   // result_last
);
    import sbq_pkg::*;

    cfg_t      cfg;
    logic      clear_state;
    logic      start;
    logic      core_ready;
    logic      out_free;
    logic      out_load;
    core_res_t core_res;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [TDATA_WIDTH-1:0] m_data_reg;
    logic                   m_last_reg;

    sbq_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .clear_state (clear_state)
    );

    assign s_tready = core_ready;
    assign start    = s_tvalid & core_ready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = core_res.valid && out_free;

    sbq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .clear_state (clear_state),
        .start       (start),
        .in_left     (sample_t'(s_tdata[SAMPLE_WIDTH-1:0])),
        .in_right    (sample_t'(s_tdata[TDATA_WIDTH-1:SAMPLE_WIDTH])),
        .in_last     (s_tlast),
        .out_free    (out_free),
        .ready       (core_ready),
        .res         (core_res)
    );

    // output register: holds a result while the next frame is computed
    always_comb
    begin
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {core_res.right, core_res.left};
            m_last_reg <= core_res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== tb/stereo_biquad_df2t_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_biquad_df2t_checker: result checker for the stereo TDF-II biquad
// Follows APB register writes and input stream transactions, computes the
// expected stereo frame for each accepted input and compares every output
// transaction with the oldest outstanding frame.
// ----------------------------------------------------------------------------
module stereo_biquad_df2t_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sbq_pkg::ADDR_WIDTH-1:0]        paddr,
    input  logic [sbq_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    input  logic                                  pready,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [sbq_pkg::TDATA_WIDTH-1:0]       s_tdata,  // left_sample, right_sample
    input  logic                                  s_tlast,  // frame_last
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [sbq_pkg::TDATA_WIDTH-1:0]       m_tdata,  // left_result, right_result
    input  logic                                  m_tlast,  // result_last
    output int                                    pending,
    output int                                    fail_count,
    output int                                    results_checked
);

    import sbq_pkg::*;

    // wide enough for every exact product and sum
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
    } stereo_frame_t;

    localparam wide_t ST_MAX = (wide_t'(1) <<< (STATE_WIDTH - 1)) - wide_t'(1);
    localparam wide_t ST_MIN = -ST_MAX - wide_t'(1);

    coef_t         coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    logic          filter_on;
    wide_t         delay_one [2];
    wide_t         delay_two [2];
    stereo_frame_t frames_due [$];
    stereo_frame_t want;
    sample_t       got_left, got_right;
    sample_t       in_left, in_right;

    function automatic wide_t clamp_state(input wide_t v);
        if (v > ST_MAX)
            return ST_MAX;
        if (v < ST_MIN)
            return ST_MIN;
        return v;
    endfunction

    // (c * v) >> frac bits on the magnitude, then clipped to the state range
    function automatic wide_t coef_product(input wide_t c, input wide_t v);
        wide_t p, mag;
        p   = c * v;
        mag = (p < 0) ? -p : p;
        mag = mag >> COEF_FRAC_BITS;
        if (p < 0)
            return (mag > ST_MAX + wide_t'(1)) ? -(ST_MAX + wide_t'(1)) : -mag;
        return (mag > ST_MAX) ? ST_MAX : mag;
    endfunction

    function automatic sample_t to_sample(input wide_t y);
        wide_t lim, q;
        lim = wide_t'(1) <<< (COEF_FRAC_BITS + 16);
        if (y > lim)
            y = lim;
        else if (y < -lim)
            y = -lim;
        q = (y * wide_t'(32767)) / (wide_t'(1) <<< (COEF_FRAC_BITS + 15));
        if (q > wide_t'(32767))
            q = wide_t'(32767);
        else if (q < -wide_t'(32768))
            q = -wide_t'(32768);
        return q[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic sample_t filter_channel(input sample_t x, input int ch);
        wide_t xw, y, n1, n2;
        xw = wide_t'(x);
        y  = clamp_state(clamp_state(wide_t'(coef_b0) * xw) + delay_one[ch]);
        n1 = clamp_state(clamp_state(wide_t'(coef_b1) * xw)
                         - coef_product(wide_t'(coef_a1), y));
        n1 = clamp_state(n1 + delay_two[ch]);
        n2 = clamp_state(clamp_state(wide_t'(coef_b2) * xw)
                         - coef_product(wide_t'(coef_a2), y));
        delay_one[ch] = n1;
        delay_two[ch] = n2;
        return to_sample(y);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0 = '0;
            coef_b1 = '0;
            coef_b2 = '0;
            coef_a1 = '0;
            coef_a2 = '0;
            filter_on = 1'b0;
            for (int ch = 0; ch < 2; ch++)
            begin
                delay_one[ch] = '0;
                delay_two[ch] = '0;
            end
            frames_due.delete();
            fail_count = 0;
            results_checked = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_WIDTH-1:2])
                    REG_B0: coef_b0 = pwdata[COEF_WIDTH-1:0];
                    REG_B1: coef_b1 = pwdata[COEF_WIDTH-1:0];
                    REG_B2: coef_b2 = pwdata[COEF_WIDTH-1:0];
                    REG_A1: coef_a1 = pwdata[COEF_WIDTH-1:0];
                    REG_A2: coef_a2 = pwdata[COEF_WIDTH-1:0];
                    REG_ENABLE:
                    begin
                        // only a 0 -> 1 change clears the delay line
                        if (!filter_on && pwdata[0])
                        begin
                            for (int ch = 0; ch < 2; ch++)
                            begin
                                delay_one[ch] = '0;
                                delay_two[ch] = '0;
                            end
                        end
                        filter_on = pwdata[0];
                    end
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got_left  = m_tdata[SAMPLE_WIDTH-1:0];
                got_right = m_tdata[TDATA_WIDTH-1:SAMPLE_WIDTH];
                if (frames_due.size() == 0)
                begin
                    $error("output transaction with no frame outstanding: left %0d right %0d",
                           got_left, got_right);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    results_checked++;
                    if (got_left !== want.left)
                    begin
                        $error("left_result mismatch: expected %0d, actual %0d",
                               want.left, got_left);
                        fail_count++;
                    end
                    if (got_right !== want.right)
                    begin
                        $error("right_result mismatch: expected %0d, actual %0d",
                               want.right, got_right);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("result_last mismatch: expected %0d, actual %0d",
                               want.last, m_tlast);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                in_left  = s_tdata[SAMPLE_WIDTH-1:0];
                in_right = s_tdata[TDATA_WIDTH-1:SAMPLE_WIDTH];
                if (filter_on)
                begin
                    want.left  = filter_channel(in_left, 0);
                    want.right = filter_channel(in_right, 1);
                end
                else
                begin
                    want.left  = in_left;
                    want.right = in_right;
                end
                want.last = s_tlast;
                frames_due.push_back(want);
            end

            pending <= frames_due.size();
        end
    end

endmodule

// ===== tb/tb_stereo_biquad_df2t.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_biquad_df2t: testbench for the stereo TDF-II biquad
// Directed bypass and saturation frames, then phases of random frames under
// stable, random and extreme coefficient sets, with random stalls on both
// stream sides. The checker instance predicts and compares every frame.
// ----------------------------------------------------------------------------
module tb_stereo_biquad_df2t;

    import sbq_pkg::*;

    // register slots past the map; writes there must not change anything
    localparam logic [IDX_WIDTH-1:0] REG_SPARE_A = IDX_WIDTH'(REG_COUNT);
    localparam logic [IDX_WIDTH-1:0] REG_SPARE_B = IDX_WIDTH'(REG_COUNT + 1);

    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam coef_t   COEF_ONE   = coef_t'(1 << COEF_FRAC_BITS);
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_FRAMES  = 150;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel, penable, pwrite;
    logic [ADDR_WIDTH-1:0]     paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      s_tvalid, s_tready;
    logic [TDATA_WIDTH-1:0]    s_tdata;   // left_sample, right_sample
    logic                      s_tlast;   // frame_last
    logic                      m_tvalid, m_tready;
    logic [TDATA_WIDTH-1:0]    m_tdata;   // left_result, right_result
    logic                      m_tlast;   // result_last

    int   pending, fail_count, results_checked;
    int   frames_sent = 0;
    int   reg_writes = 0;
    int   coef_sets = 0;
    logic no_idle = 1'b0;

    stereo_biquad_df2t uut (.*);

    stereo_biquad_df2t_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic apb_write(input logic [IDX_WIDTH-1:0] idx,
                             input logic [APB_DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // upper bits carry noise; only the low coefficient bits count
    task automatic write_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                               input coef_t a1, input coef_t a2);
        apb_write(REG_B0, {6'($urandom), b0});
        apb_write(REG_B1, {6'($urandom), b1});
        apb_write(REG_B2, {6'($urandom), b2});
        apb_write(REG_A1, {6'($urandom), a1});
        apb_write(REG_A2, {6'($urandom), a2});
        coef_sets++;
    endtask

    task automatic set_enable(input logic en);
        apb_write(REG_ENABLE, {31'($urandom), en});
    endtask

    task automatic send_frame(input sample_t left, input sample_t right, input logic last);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        frames_sent++;
    endtask

    // wait until every outstanding frame is back and the core has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return sample_t'(int'($urandom_range(0, 512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t extreme_coef();
        case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return '1;
            default: return COEF_ONE;
        endcase
    endfunction

    task automatic run_phase(input int count);
        int    style, a2_val, a1_lim;
        coef_t c [5];
        logic  en;
        style = $urandom_range(0, 3);
        if (style <= 1)
        begin
            // poles inside the stability triangle, moderate gain
            a2_val = $urandom_range(0, 3774873);
            a1_lim = ((4194304 + a2_val) / 10) * 9;
            c[0] = coef_t'(int'($urandom_range(0, 4194304)) - 2097152);
            c[1] = coef_t'(int'($urandom_range(0, 4194304)) - 2097152);
            c[2] = coef_t'(int'($urandom_range(0, 4194304)) - 2097152);
            c[3] = coef_t'(int'($urandom_range(0, 2 * a1_lim)) - a1_lim);
            c[4] = coef_t'(a2_val);
        end
        else
        begin
            for (int k = 0; k < 5; k++)
                c[k] = (style == 2) ? coef_t'($urandom) : extreme_coef();
        end
        write_coefs(c[0], c[1], c[2], c[3], c[4]);
        en = ($urandom_range(0, 4) != 0);
        if (en && $urandom_range(0, 2) == 0)
            set_enable(1'b0);
        set_enable(en);
        repeat (count) send_frame(random_sample(), random_sample(), $urandom_range(0, 7) == 0);
        drain();
    endtask

    initial
    begin
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 10);
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass straight out of reset
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(sample_t'(0), sample_t'(-1), 1'b1);
        send_frame(sample_t'(16'h5555), sample_t'(16'haaaa), 1'b0);
        drain();

        // unity b0: output is x scaled by 32767/32768
        write_coefs(COEF_ONE, '0, '0, '0, '0);
        set_enable(1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_frame(sample_t'(1), sample_t'(-1), 1'b0);
        send_frame(sample_t'(0), sample_t'(0), 1'b1);
        drain();

        // heavy feedback, rewriting enable as 1 keeps the delay line
        write_coefs(COEF_ONE, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
        set_enable(1'b1);
        repeat (3) send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        repeat (3) send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        drain();

        write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        drain();

        // disable holds state, re-enable clears it; spare slots are ignored
        set_enable(1'b0);
        send_frame(sample_t'(-1234), sample_t'(4321), 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        drain();
        set_enable(1'b1);
        apb_write(REG_SPARE_A, $urandom);
        apb_write(REG_SPARE_B, $urandom);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(sample_t'(100), sample_t'(-100), 1'b0);
        send_frame(sample_t'(0), sample_t'(0), 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_idle <= (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
            run_phase(PHASE_FRAMES);
        end

        repeat (150) @(posedge clk);
        $display("Covered %0d frames, %0d checked, over %0d coefficient sets in bypass and filtering",
                 frames_sent, results_checked, coef_sets);
        $display("with %0d register writes, enable toggles and random stalls on both stream sides",
                 reg_writes);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sbq_pkg.sv
design/sbq_mul.sv
design/sbq_regs.sv
design/sbq_core.sv
design/stereo_biquad_df2t.sv
tb/stereo_biquad_df2t_checker.sv
tb/tb_stereo_biquad_df2t.sv
